FILE: rtl/stereo_balance_delay_unit_assert.svh
// assertion macros shared by the stereo balance delay unit
`ifndef STEREO_BALANCE_DELAY_UNIT_ASSERT_SVH
`define STEREO_BALANCE_DELAY_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define SBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

    // default sizes
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int DELAY_DEPTH_DEF  = 4096;

    // register field widths
    localparam int GAIN_W     = 16;
    localparam int BAL_W      = 16;
    localparam int MONO_W     = 2;
    localparam int FLAGS_W    = 3;
    localparam int DELAY_W    = 20;
    localparam int FRAC_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // q14 gain arithmetic
    localparam int Q_SHIFT = 14;
    localparam int UNITY   = 16384;
    localparam int Q_HALF  = 8192;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_GAIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_GAIN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BALANCE       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MONO_MODE     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_FLAGS = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_DELAY    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_DELAY   = 3'd6;

    // mono modes
    localparam logic [MONO_W-1:0] MONO_OFF   = 2'd0;
    localparam logic [MONO_W-1:0] MONO_SUM   = 2'd1;
    localparam logic [MONO_W-1:0] MONO_LEFT  = 2'd2;
    localparam logic [MONO_W-1:0] MONO_RIGHT = 2'd3;

    // channel flag bit positions
    localparam int FLAG_SWAP  = 0;
    localparam int FLAG_INV_L = 1;
    localparam int FLAG_INV_R = 2;

    // steps of the gain and mix datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic sat;
    } mix_ctrl_t;

    // steps of a delay line
    typedef struct packed {
        logic wr;
        logic rd2;
        logic ip;
        logic fin;
    } line_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sbd_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module sbd_mix #(
    parameter int SW = sbd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire sbd_pkg::mix_ctrl_t              ctrl,
    input  wire logic [SW-1:0]                   in_left,
    input  wire logic [SW-1:0]                   in_right,
    input  wire logic                            single_ch,
    input  wire logic [sbd_pkg::GAIN_W-1:0]      left_gain,
    input  wire logic [sbd_pkg::GAIN_W-1:0]      right_gain,
    input  wire logic [sbd_pkg::BAL_W-1:0]       balance,
    input  wire logic [sbd_pkg::MONO_W-1:0]      mono_mode,
    input  wire logic [sbd_pkg::FLAGS_W-1:0]     flags,
    output logic      [SW-1:0]                   out_left,
    output logic      [SW-1:0]                   out_right
);

    localparam int GW = sbd_pkg::GAIN_W;
    localparam int BW = sbd_pkg::BAL_W;
    localparam int Q  = sbd_pkg::Q_SHIFT;
    localparam int FW = Q + 1;
    localparam int PW = SW + GW + 1;
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

    logic [GW-1:0]          lg_eff_reg, rg_eff_reg;
    logic [SW-1:0]          l_reg, r_reg;
    logic signed [PW-1:0]   pl_reg, pr_reg;
    logic [SW-1:0]          lv_reg, rv_reg;

    logic                   bal_neg;
    logic [BW:0]            bal_ext, bal_mag, mag_c;
    logic [FW-1:0]          factor;
    logic [GW+FW-1:0]       fl_sum, fr_sum;
    logic [SW-1:0]          r_src, l_sel, r_sel;
    logic [SW-1:0]          l_sat, r_sat;
    logic [SW:0]            mono_sum;

    // round half up by q14 and saturate to the sample range
    function automatic logic [SW-1:0] round_sat(input logic [PW-1:0] p);
        logic [PW:0]   r;
        logic [PW-Q:0] s;
        r = {p[PW-1], p} + (PW+1)'(sbd_pkg::Q_HALF);
        s = r[PW:Q];
        if (&s[PW-Q:SW-1] || ~|s[PW-Q:SW-1]) begin
            return s[SW-1:0];
        end
        return s[PW-Q] ? S_MIN : S_MAX;
    endfunction

    // negate with saturation of the most negative sample
    function automatic logic [SW-1:0] neg_sat(input logic [SW-1:0] v);
        return (v == S_MIN) ? S_MAX : SW'(-v);
    endfunction

    // balance folded into one of the gains, tracked every cycle
    assign bal_neg = balance[BW-1];
    assign bal_ext = {balance[BW-1], balance};
    assign bal_mag = bal_neg ? (BW+1)'(-bal_ext) : bal_ext;
    assign mag_c   = (bal_mag > (BW+1)'(sbd_pkg::UNITY)) ? (BW+1)'(sbd_pkg::UNITY) : bal_mag;
    assign factor  = FW'((BW+1)'(sbd_pkg::UNITY) - mag_c);
    assign fl_sum  = ({{FW{1'b0}}, left_gain} * {{GW{1'b0}}, factor})
                     + (GW+FW)'(sbd_pkg::Q_HALF);
    assign fr_sum  = ({{FW{1'b0}}, right_gain} * {{GW{1'b0}}, factor})
                     + (GW+FW)'(sbd_pkg::Q_HALF);

    always_ff @(posedge aclk) begin
        lg_eff_reg <= bal_neg ? left_gain : fl_sum[Q+GW-1:Q];
        rg_eff_reg <= bal_neg ? fr_sum[Q+GW-1:Q] : right_gain;
    end

    // source selection and swap at request acceptance
    assign r_src = single_ch ? in_left : in_right;
    assign l_sel = flags[sbd_pkg::FLAG_SWAP] ? r_src : in_left;
    assign r_sel = flags[sbd_pkg::FLAG_SWAP] ? in_left : r_src;

    // gain products, then rounding, saturation and invert
    assign l_sat = round_sat(pl_reg);
    assign r_sat = round_sat(pr_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            l_reg <= l_sel;
            r_reg <= r_sel;
        end
        if (ctrl.mul) begin
            pl_reg <= $signed({{(PW-SW){l_reg[SW-1]}}, l_reg})
                      * $signed({{(PW-GW){1'b0}}, lg_eff_reg});
            pr_reg <= $signed({{(PW-SW){r_reg[SW-1]}}, r_reg})
                      * $signed({{(PW-GW){1'b0}}, rg_eff_reg});
        end
        if (ctrl.sat) begin
            lv_reg <= flags[sbd_pkg::FLAG_INV_L] ? neg_sat(l_sat) : l_sat;
            rv_reg <= flags[sbd_pkg::FLAG_INV_R] ? neg_sat(r_sat) : r_sat;
        end
    end

    // mono mode on the processed pair
    assign mono_sum = {lv_reg[SW-1], lv_reg} + {rv_reg[SW-1], rv_reg};

    always_comb begin
        out_left  = lv_reg;
        out_right = rv_reg;
        unique case (mono_mode)
            sbd_pkg::MONO_OFF: begin
                out_left  = lv_reg;
                out_right = rv_reg;
            end
            sbd_pkg::MONO_SUM: begin
                out_left  = mono_sum[SW:1];
                out_right = mono_sum[SW:1];
            end
            sbd_pkg::MONO_LEFT: begin
                out_right = '0;
            end
            sbd_pkg::MONO_RIGHT: begin
                out_left = '0;
            end
            default: begin
                out_left  = lv_reg;
                out_right = rv_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/sbd_line.sv
`timescale 1ns / 1ps
`default_nettype none

module sbd_line #(
    parameter int DEPTH = sbd_pkg::DELAY_DEPTH_DEF,
    parameter int SW    = sbd_pkg::SAMPLE_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire sbd_pkg::line_ctrl_t           ctrl,
    input  wire logic [AW-1:0]                 wp,
    input  wire logic                          wrapped,
    input  wire logic [SW-1:0]                 sample_in,
    input  wire logic [sbd_pkg::DELAY_W-1:0]   delay,
    output logic      [SW-1:0]                 sample_out
);

    localparam int FRW     = sbd_pkg::FRAC_W;
    localparam int WHOLE_W = sbd_pkg::DELAY_W - FRW;
    localparam int CW      = ((WHOLE_W > AW) ? WHOLE_W : AW) + 1;
    localparam int PRW     = SW + FRW + 2;
    localparam logic [CW-1:0] WHOLE_MAX = CW'(DEPTH - 2);
    localparam logic [AW:0]   DEPTH_C   = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

    logic [SW-1:0]  mem [DEPTH];
    logic [SW-1:0]  rd_reg, new_reg, s1_reg, out_reg;
    logic           hit1_reg, ok1_reg, hit2_reg, ok2_reg;
    logic [PRW-1:0] prod_reg;

    logic [CW-1:0]  whole_w;
    logic           clamp;
    logic [AW-1:0]  whole_c;
    logic [FRW-1:0] frac_c;
    logic [AW:0]    diff;
    logic [AW-1:0]  i1, i2, rd_addr;
    logic [SW-1:0]  s1_pick, s2_pick;
    logic [SW:0]    step;
    logic [PRW-1:0] rnd;

    // delay split and limited to the store length
    assign whole_w = CW'(delay[sbd_pkg::DELAY_W-1:FRW]);
    assign clamp   = whole_w > WHOLE_MAX;
    assign whole_c = clamp ? WHOLE_MAX[AW-1:0] : whole_w[AW-1:0];
    assign frac_c  = clamp ? '0 : delay[FRW-1:0];

    // tap addresses behind the write pointer, wrapped round the store
    assign diff    = {1'b0, wp} - {1'b0, whole_c};
    assign i1      = diff[AW] ? AW'(diff + DEPTH_C) : diff[AW-1:0];
    assign i2      = (i1 == '0) ? LAST_IDX : AW'(i1 - 1'b1);
    assign rd_addr = ctrl.wr ? i1 : i2;

    // sample store: write the new sample, read the first tap, then the second
    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            mem[wp] <= sample_in;
        end
        if (ctrl.wr || ctrl.rd2) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // entries not yet written since reset read as silence
    assign s1_pick = hit1_reg ? new_reg : (ok1_reg ? rd_reg : '0);
    assign s2_pick = hit2_reg ? new_reg : (ok2_reg ? rd_reg : '0);

    // linear interpolation between the two taps
    assign step = {s2_pick[SW-1], s2_pick} - {s1_reg[SW-1], s1_reg};
    assign rnd  = prod_reg + PRW'(1 << (FRW - 1));

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            new_reg  <= sample_in;
            hit1_reg <= (i1 == wp);
            ok1_reg  <= wrapped || (i1 <= wp);
        end
        if (ctrl.rd2) begin
            s1_reg   <= s1_pick;
            hit2_reg <= (i2 == wp);
            ok2_reg  <= wrapped || (i2 <= wp);
        end
        if (ctrl.ip) begin
            prod_reg <= $signed({{(PRW-SW-1){step[SW]}}, step})
                        * $signed({{(PRW-FRW){1'b0}}, frac_c});
        end
        if (ctrl.fin) begin
            out_reg <= SW'(s1_reg + rnd[FRW+SW-1:FRW]);
        end
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

FILE: rtl/stereo_balance_delay_unit.sv
// stereo balance and fractional delay unit
// input stream: one stereo frame per request; s_tdata carries left_in and
// right_in, s_tuser is single_channel (right copies left), s_tlast marks the
// last frame of a host block and is passed to m_tlast.
// output stream: m_tdata carries left_out and right_out, one result per frame.
// configuration: cfg_wr_en writes cfg_wdata into register cfg_addr (gains,
// balance, mono mode, channel flags, delays); write only while idle.
// each frame runs through a fixed sequence: gain multiply, round and
// saturate, mono mix with delay store write and first tap read, second tap
// read, interpolation multiply, final add into the output register.
// s_tready is high only while idle, so a new frame is taken only after the
// previous one leaves its final step; the sequence length is set by the two
// reads per channel from the single read port of each delay store and the two multiply steps.
// the output register lets a finished frame wait while the next one runs;
// a stalled receiver holds the sequence in its final step until taken.
// reset clears the delay lines logically (entries above the write pointer
// read as zero until the pointer first wraps), the write pointer, the output
// valid and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_balance_delay_unit_assert.svh"

module stereo_balance_delay_unit #(
    parameter int DELAY_DEPTH  = sbd_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = sbd_pkg::SAMPLE_WIDTH_DEF,
    localparam int TW          = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int AW          = $clog2(DELAY_DEPTH)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input frames
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [TW-1:0]                     s_tdata,   // left_in, right_in
    input  wire logic                              s_tuser,   // single_channel
    input  wire logic                              s_tlast,   // end_of_block
    // result frames
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [TW-1:0]                     m_tdata,   // left_out, right_out
    output logic                                   m_tlast,   // end_of_block_out
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [sbd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [sbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SW = SAMPLE_WIDTH;
    localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_WR,
        ST_RD,
        ST_IP,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   m_tlast_reg, m_tlast_next;
    logic   eob_reg, eob_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic   wrapped_reg, wrapped_next;

    logic [sbd_pkg::GAIN_W-1:0]  left_gain_reg, right_gain_reg;
    logic [sbd_pkg::BAL_W-1:0]   balance_reg;
    logic [sbd_pkg::MONO_W-1:0]  mono_mode_reg;
    logic [sbd_pkg::FLAGS_W-1:0] flags_reg;
    logic [sbd_pkg::DELAY_W-1:0] left_delay_reg, right_delay_reg;

    logic                s_accept, fin_go;
    sbd_pkg::mix_ctrl_t  mix_ctrl;
    sbd_pkg::line_ctrl_t line_ctrl;
    logic [SW-1:0]       mix_left, mix_right, left_out, right_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_gain_reg   <= sbd_pkg::GAIN_W'(sbd_pkg::UNITY);
            right_gain_reg  <= sbd_pkg::GAIN_W'(sbd_pkg::UNITY);
            balance_reg     <= '0;
            mono_mode_reg   <= sbd_pkg::MONO_OFF;
            flags_reg       <= '0;
            left_delay_reg  <= '0;
            right_delay_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sbd_pkg::REG_LEFT_GAIN:     left_gain_reg   <= cfg_wdata[sbd_pkg::GAIN_W-1:0];
                sbd_pkg::REG_RIGHT_GAIN:    right_gain_reg  <= cfg_wdata[sbd_pkg::GAIN_W-1:0];
                sbd_pkg::REG_BALANCE:       balance_reg     <= cfg_wdata[sbd_pkg::BAL_W-1:0];
                sbd_pkg::REG_MONO_MODE:     mono_mode_reg   <= cfg_wdata[sbd_pkg::MONO_W-1:0];
                sbd_pkg::REG_CHANNEL_FLAGS: flags_reg       <= cfg_wdata[sbd_pkg::FLAGS_W-1:0];
                sbd_pkg::REG_LEFT_DELAY:    left_delay_reg  <= cfg_wdata;
                sbd_pkg::REG_RIGHT_DELAY:   right_delay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshakes and step strobes
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    assign mix_ctrl.load = s_accept;
    assign mix_ctrl.mul  = (state_reg == ST_MUL);
    assign mix_ctrl.sat  = (state_reg == ST_SAT);

    assign line_ctrl.wr  = (state_reg == ST_WR);
    assign line_ctrl.rd2 = (state_reg == ST_RD);
    assign line_ctrl.ip  = (state_reg == ST_IP);
    assign line_ctrl.fin = fin_go;

    // frame sequencer
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        eob_next      = eob_reg;
        wp_next       = wp_reg;
        wrapped_next  = wrapped_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    eob_next   = s_tlast;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_SAT;
            ST_SAT: state_next = ST_WR;
            ST_WR:  state_next = ST_RD;
            ST_RD:  state_next = ST_IP;
            ST_IP:  state_next = ST_FIN;
            ST_FIN: begin
                if (fin_go) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = eob_reg;
                    if (wp_reg == WP_LAST) begin
                        wp_next      = '0;
                        wrapped_next = 1'b1;
                    end else begin
                        wp_next = AW'(wp_reg + 1'b1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            eob_reg      <= 1'b0;
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
            eob_reg      <= eob_next;
            wp_reg       <= wp_next;
            wrapped_reg  <= wrapped_next;
        end
    end

    // gain, balance, invert and mono datapath
    sbd_mix #(
        .SW(SW)
    ) u_mix (
        .aclk       (aclk),
        .ctrl       (mix_ctrl),
        .in_left    (s_tdata[SW-1:0]),
        .in_right   (s_tdata[2*SW-1:SW]),
        .single_ch  (s_tuser),
        .left_gain  (left_gain_reg),
        .right_gain (right_gain_reg),
        .balance    (balance_reg),
        .mono_mode  (mono_mode_reg),
        .flags      (flags_reg),
        .out_left   (mix_left),
        .out_right  (mix_right)
    );

    // one delay line per channel
    sbd_line #(
        .DEPTH(DELAY_DEPTH),
        .SW   (SW)
    ) u_line_left (
        .aclk       (aclk),
        .ctrl       (line_ctrl),
        .wp         (wp_reg),
        .wrapped    (wrapped_reg),
        .sample_in  (mix_left),
        .delay      (left_delay_reg),
        .sample_out (left_out)
    );

    sbd_line #(
        .DEPTH(DELAY_DEPTH),
        .SW   (SW)
    ) u_line_right (
        .aclk       (aclk),
        .ctrl       (line_ctrl),
        .wp         (wp_reg),
        .wrapped    (wrapped_reg),
        .sample_in  (mix_right),
        .delay      (right_delay_reg),
        .sample_out (right_out)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = TW'({right_out, left_out});

    // checks
    `SBD_ASSERT_NXT(a_wp_step, aclk, aresetn, fin_go, wp_reg == (($past(wp_reg) == WP_LAST) ? '0 : AW'($past(wp_reg) + 1'b1)), "write pointer did not advance by one")
    `SBD_ASSERT_NXT(a_wp_hold, aclk, aresetn, !fin_go, $stable(wp_reg), "write pointer moved without a finished frame")
    `SBD_ASSERT_IMP(a_valid_rise, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == ST_FIN), "result shown without a finished frame")
    `SBD_ASSERT_IMP(a_wrap_point, aclk, aresetn, $rose(wrapped_reg), wp_reg == '0, "wrap flag set away from the pointer wrap")

endmodule

`default_nettype wire
